@@ rtl/ccl_pkg.sv @@
// ----------------------------------------------------------------------------
// ccl_pkg: shared types for the chunk cache tag and policy engine
// Beat formats, request codes, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ccl_pkg;

   localparam int AGE_W      = 32;
   localparam int CHUNK_W    = 20;
   localparam int SLOT_NUM_W = 3;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_STORE = 2'd1,
      REQ_FLUSH = 2'd2,
      REQ_INVAL = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type         req_type;
      logic [CHUNK_W-1:0]   chunk_number;
   } ccl_req_beat_type;

   typedef struct packed {
      logic [SLOT_NUM_W-1:0] slot_number;
      logic                  was_hit;
      logic                  fill_needed;
      logic                  writeback_valid;
      logic [CHUNK_W-1:0]    writeback_chunk;
      logic                  last_result;
   } ccl_rsp_beat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_UPDATE,
      ST_FLUSH,
      ST_INVAL,
      ST_RESP
   } ccl_state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic scan_step;
      logic commit;
      logic flush_step;
      logic invalidate;
   } ccl_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_last;
      logic flush_emit;
      logic rsp_fire;
      logic rsp_last;
   } ccl_stat_type;

endpackage

@@ rtl/ccl_ctrl.sv @@
// ----------------------------------------------------------------------------
// ccl_ctrl: request sequencer
// Steps each request through lookup, victim scan, update, flush walk or
// invalidate, and holds in the response state until the beat is taken.
// ----------------------------------------------------------------------------
module ccl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  ccl_pkg::req_kind_type req_kind,
   output logic                  req_ready,
   input  ccl_pkg::ccl_stat_type stat,
   output ccl_pkg::ccl_cmd_type  cmd
);

   ccl_pkg::ccl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ccl_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  ccl_pkg::REQ_FLUSH: state_in = ccl_pkg::ST_FLUSH;
                  ccl_pkg::REQ_INVAL: state_in = ccl_pkg::ST_INVAL;
                  default:            state_in = ccl_pkg::ST_LOOKUP;
               endcase
            end
         end
         ccl_pkg::ST_LOOKUP: begin
            state_in = stat.need_scan ? ccl_pkg::ST_SCAN : ccl_pkg::ST_UPDATE;
         end
         ccl_pkg::ST_SCAN: begin
            if (stat.scan_last) state_in = ccl_pkg::ST_UPDATE;
         end
         ccl_pkg::ST_UPDATE: state_in = ccl_pkg::ST_RESP;
         ccl_pkg::ST_INVAL:  state_in = ccl_pkg::ST_RESP;
         ccl_pkg::ST_FLUSH: begin
            if (stat.flush_emit) state_in = ccl_pkg::ST_RESP;
         end
         ccl_pkg::ST_RESP: begin
            // only flush beats can be non-final; resume the walk after them
            if (stat.rsp_fire) begin
               state_in = stat.rsp_last ? ccl_pkg::ST_IDLE : ccl_pkg::ST_FLUSH;
            end
         end
         default: state_in = ccl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == ccl_pkg::ST_IDLE);
      cmd            = '0;
      cmd.capture    = (state_ff == ccl_pkg::ST_IDLE) && req_valid;
      cmd.lookup     = (state_ff == ccl_pkg::ST_LOOKUP);
      cmd.scan_step  = (state_ff == ccl_pkg::ST_SCAN);
      cmd.commit     = (state_ff == ccl_pkg::ST_UPDATE);
      cmd.flush_step = (state_ff == ccl_pkg::ST_FLUSH);
      cmd.invalidate = (state_ff == ccl_pkg::ST_INVAL);
   end

endmodule

@@ rtl/ccl_datapath.sv @@
// ----------------------------------------------------------------------------
// ccl_datapath: slot state, tag match, victim scan and response register
// Holds tags, valid, dirty and age per slot plus the global age counter,
// and builds each response beat into a register held until taken.
// ----------------------------------------------------------------------------
module ccl_datapath #(
   parameter int NUM_SLOTS  = 8,
   parameter int CHUNK_BITS = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ccl_pkg::ccl_cmd_type      cmd,
   output ccl_pkg::ccl_stat_type     stat,
   input  ccl_pkg::ccl_req_beat_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ccl_pkg::ccl_rsp_beat_type rsp_data
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [ccl_pkg::AGE_W-1:0] AGE_MAX = '1;

   // captured request
   ccl_pkg::req_kind_type     kind_ff;
   logic [CHUNK_BITS-1:0]     chunk_ff;

   // slot state
   logic                      valid_ff [NUM_SLOTS];
   logic                      dirty_ff [NUM_SLOTS];
   logic [ccl_pkg::AGE_W-1:0] age_ff   [NUM_SLOTS];
   logic [CHUNK_BITS-1:0]     tag_ff   [NUM_SLOTS];
   logic [ccl_pkg::AGE_W-1:0] counter_ff, counter_in;

   // access bookkeeping
   logic [IDX_W-1:0]          sel_ff;
   logic                      hit_ff;
   logic [ccl_pkg::AGE_W-1:0] min_age_ff;
   logic [IDX_W-1:0]          walk_ff;

   ccl_pkg::ccl_rsp_beat_type rsp_ff, rsp_in;
   logic                      rsp_valid_ff;

   logic                      hit_any, free_any;
   logic [IDX_W-1:0]          hit_idx, free_idx;
   logic [NUM_SLOTS-1:0]      dv_ge, dv_gt;
   logic                      cur_dv, rem_any, above_any;
   logic                      wb_valid;
   logic                      rsp_fire, emit;

   // parallel tag match and first free slot, lowest index wins
   always_comb begin
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tag_ff[i] == chunk_ff)) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // dirty slots at or above the flush walk position
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         dv_ge[i] = valid_ff[i] && dirty_ff[i] && (IDX_W'(i) >= walk_ff);
         dv_gt[i] = valid_ff[i] && dirty_ff[i] && (IDX_W'(i) > walk_ff);
      end
   end

   assign cur_dv    = valid_ff[walk_ff] && dirty_ff[walk_ff];
   assign rem_any   = |dv_ge;
   assign above_any = |dv_gt;
   assign wb_valid  = !hit_ff && valid_ff[sel_ff] && dirty_ff[sel_ff];
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign emit      = cmd.commit || cmd.invalidate ||
                      (cmd.flush_step && (cur_dv || !rem_any));

   assign counter_in = (counter_ff == AGE_MAX) ? counter_ff
                                               : counter_ff + 1'b1;

   always_comb begin
      rsp_in = '0;
      if (cmd.commit) begin
         rsp_in.slot_number     = ccl_pkg::SLOT_NUM_W'(sel_ff);
         rsp_in.was_hit         = hit_ff;
         rsp_in.fill_needed     = !hit_ff;
         rsp_in.writeback_valid = wb_valid;
         rsp_in.writeback_chunk = wb_valid ? ccl_pkg::CHUNK_W'(tag_ff[sel_ff]) : '0;
         rsp_in.last_result     = 1'b1;
      end else if (cmd.flush_step && cur_dv) begin
         rsp_in.slot_number     = ccl_pkg::SLOT_NUM_W'(walk_ff);
         rsp_in.writeback_valid = 1'b1;
         rsp_in.writeback_chunk = ccl_pkg::CHUNK_W'(tag_ff[walk_ff]);
         rsp_in.last_result     = !above_any;
      end else begin
         // invalidate ack, or flush with nothing dirty
         rsp_in.last_result     = 1'b1;
      end
   end

   // control-side slot state and counter
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
            dirty_ff[i] <= 1'b0;
            age_ff[i]   <= '0;
         end
         counter_ff   <= ccl_pkg::AGE_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.invalidate) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               valid_ff[i] <= 1'b0;
               dirty_ff[i] <= 1'b0;
               age_ff[i]   <= '0;
            end
            counter_ff <= ccl_pkg::AGE_W'(1);
         end
         if (cmd.commit) begin
            valid_ff[sel_ff] <= 1'b1;
            dirty_ff[sel_ff] <= (kind_ff == ccl_pkg::REQ_STORE) ||
                                (hit_ff && dirty_ff[sel_ff]);
            age_ff[sel_ff]   <= counter_ff;
            counter_ff       <= counter_in;
         end
         if (cmd.flush_step && cur_dv) begin
            dirty_ff[walk_ff] <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_data.req_type;
         chunk_ff <= CHUNK_BITS'(req_data.chunk_number);
         walk_ff  <= '0;
      end
      if (cmd.lookup) begin
         if (hit_any) begin
            sel_ff <= hit_idx;
            hit_ff <= 1'b1;
         end else if (free_any) begin
            sel_ff <= free_idx;
            hit_ff <= 1'b0;
         end else begin
            // all slots full: take slot 0 as the first candidate and walk the ages from slot 1
            sel_ff     <= '0;
            hit_ff     <= 1'b0;
            min_age_ff <= age_ff[0];
            walk_ff    <= IDX_W'(1);
         end
      end
      if (cmd.scan_step) begin
         if (age_ff[walk_ff] < min_age_ff) begin
            min_age_ff <= age_ff[walk_ff];
            sel_ff     <= walk_ff;
         end
         walk_ff <= walk_ff + 1'b1;
      end
      if (cmd.flush_step) begin
         walk_ff <= walk_ff + 1'b1;
      end
      if (cmd.commit && !hit_ff) begin
         tag_ff[sel_ff] <= chunk_ff;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      stat            = '0;
      stat.need_scan  = !hit_any && !free_any && (NUM_SLOTS > 1);
      stat.scan_last  = (walk_ff == IDX_W'(NUM_SLOTS - 1));
      stat.flush_emit = cur_dv || !rem_any;
      stat.rsp_fire   = rsp_fire;
      stat.rsp_last   = rsp_ff.last_result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/chunk_cache_lru_writeback_top.sv @@
// ----------------------------------------------------------------------------
// chunk_cache_lru_writeback_top: fully associative LRU write-back chunk cache
// One request is handled at a time; req_ready is high only while idle, and
// the next request is taken in the cycle after the previous last response
// beat is accepted. A load or store that hits, or misses with a free slot,
// has a single beat, made by a parallel tag match and then the state
// update. A miss with every slot full walks the slot ages one slot per
// cycle for the oldest entry. A flush walks the slots one per cycle from
// slot 0, stopping at each dirty slot until its beat is taken; invalidate
// clears every slot and answers with one beat.
// ----------------------------------------------------------------------------
module chunk_cache_lru_writeback_top #(
   parameter int NUM_SLOTS  = 8,
   parameter int CHUNK_BITS = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ccl_pkg::ccl_req_beat_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ccl_pkg::ccl_rsp_beat_type rsp_data
);

   ccl_pkg::ccl_cmd_type  cmd;
   ccl_pkg::ccl_stat_type stat;

   ccl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ccl_datapath #(
      .NUM_SLOTS  (NUM_SLOTS),
      .CHUNK_BITS (CHUNK_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
